// File: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cursor engine
// Screen geometry, character codes, mode codes and the memory request bundle.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_LEN    = CELL_COUNT - SCREEN_COLS;

  // Field widths
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 8;
  localparam int CHAR_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Color after reset
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT = 1'b1;

  // Command modes
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Cell memory request bundle: one write and one read request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Linear cell index of a row and column
  function automatic logic [ADDR_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    lin_addr = ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  endfunction

endpackage

// File: rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl: cursor sequencer of the text console
// Runs one command at a time over the cell memory through a shared
// row-times-width address unit: put, backspace scan, scroll, fill and read.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          mode,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [COL_W-1:0]    read_col,
  input  logic [ROW_W-1:0]    read_row,
  input  logic [COLOR_W-1:0]  text_color,
  input  logic [POS_W-1:0]    erase_limit,
  input  logic [CELL_W-1:0]   rdata,
  output mem_req_t            mreq,
  output logic                busy,
  output logic                done,
  output logic [POS_W-1:0]    cursor_pos,
  output logic [CHAR_W-1:0]   read_char
);

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_RD_WAIT  = 8'b0000_0100,
    S_SCROLL   = 8'b0000_1000,
    S_FILL     = 8'b0001_0000,
    S_SCAN_RD  = 8'b0010_0000,
    S_SCAN_CMP = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [COL_W-1:0]    col, col_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  logic                wr_pend, wr_pend_next;
  logic [ADDR_W-1:0]   wr_addr, wr_addr_next;
  logic [CHAR_W-1:0]   rd_char, rd_char_next;

  logic                lin_sel_read;
  logic [ROW_W-1:0]    lin_row;
  logic [COL_W-1:0]    lin_col;
  logic [ADDR_W-1:0]   lin;
  logic                read_in_range;
  logic [CHAR_W-1:0]   put_ch;

  // Shared address unit: read coordinates on a read command, else the cursor
  assign lin_sel_read  = (state == S_IDLE) && (mode_t'(mode) == MODE_READ);
  assign lin_row       = lin_sel_read ? read_row : row;
  assign lin_col       = lin_sel_read ? read_col : col;
  assign lin           = lin_addr(lin_row, lin_col);

  assign read_in_range = (int'(read_col) < SCREEN_COLS) && (int'(read_row) < SCREEN_ROWS);
  assign put_ch        = (char_code == CH_NEWLINE) ? CH_NUL : char_code;

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign cursor_pos = POS_W'(lin);
  assign read_char  = rd_char;

  // Sequencer
  always_comb begin
    state_next   = state;
    row_next     = row;
    col_next     = col;
    cnt_next     = cnt;
    wr_pend_next = 1'b0;
    wr_addr_next = wr_addr;
    rd_char_next = rd_char;
    mreq         = '0;

    case (state)
      // Sweep the screen to spaces in the reset color
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = cnt;
        mreq.wdata = {RESET_COLOR, CH_SPACE};
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end

      // Decode a command on transfer
      S_IDLE: begin
        if (start) begin
          rd_char_next = CH_NUL;
          state_next   = S_DONE;
          case (mode_t'(mode))
            MODE_PUT: begin
              if (char_code == CH_BACKSPACE) begin
                if (POS_W'(lin) == erase_limit) begin
                  state_next = S_DONE;
                end else if (col != '0) begin
                  col_next   = col - COL_W'(1);
                  mreq.we    = 1'b1;
                  mreq.waddr = lin - ADDR_W'(1);
                  mreq.wdata = {text_color, CH_SPACE};
                end else if (row != '0) begin
                  row_next   = row - ROW_W'(1);
                  col_next   = COL_W'(SCREEN_COLS - 1);
                  state_next = S_SCAN_RD;
                end
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = lin;
                mreq.wdata = {text_color, put_ch};
                if (char_code == CH_NEWLINE || col == COL_W'(SCREEN_COLS - 1)) begin
                  col_next = '0;
                  if (row == ROW_W'(SCREEN_ROWS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SCROLL;
                  end else begin
                    row_next = row + ROW_W'(1);
                  end
                end else begin
                  col_next = col + COL_W'(1);
                end
              end
            end
            MODE_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              cnt_next   = '0;
              state_next = S_FILL;
            end
            MODE_READ: begin
              if (read_in_range) begin
                mreq.re    = 1'b1;
                mreq.raddr = lin;
                state_next = S_RD_WAIT;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Capture the addressed character
      S_RD_WAIT: begin
        rd_char_next = rdata[CHAR_W-1:0];
        state_next   = S_DONE;
      end

      // Copy each cell one row up; the write of each cell is registered behind its read
      S_SCROLL: begin
        if (wr_pend) begin
          mreq.we    = 1'b1;
          mreq.waddr = wr_addr;
          mreq.wdata = rdata;
        end
        if (cnt != ADDR_W'(COPY_LEN)) begin
          mreq.re      = 1'b1;
          mreq.raddr   = cnt + ADDR_W'(SCREEN_COLS);
          wr_addr_next = cnt;
          wr_pend_next = 1'b1;
          cnt_next     = cnt + ADDR_W'(1);
        end else begin
          state_next = S_FILL;
        end
      end

      // Fill from cnt to the last cell with spaces in the current color
      S_FILL: begin
        mreq.we    = 1'b1;
        mreq.waddr = cnt;
        mreq.wdata = {text_color, CH_SPACE};
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end

      // Backspace scan: fetch the cell under the cursor
      S_SCAN_RD: begin
        mreq.re    = 1'b1;
        mreq.raddr = lin;
        state_next = S_SCAN_CMP;
      end

      // Step left over spaces, stop at column 0, then erase
      S_SCAN_CMP: begin
        if (col != '0 && rdata[CHAR_W-1:0] == CH_SPACE) begin
          col_next   = col - COL_W'(1);
          state_next = S_SCAN_RD;
        end else begin
          mreq.we    = 1'b1;
          mreq.waddr = lin;
          mreq.wdata = {text_color, CH_SPACE};
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      row     <= '0;
      col     <= '0;
      cnt     <= '0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      row     <= row_next;
      col     <= col_next;
      cnt     <= cnt_next;
      wr_pend <= wr_pend_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    rd_char <= rd_char_next;
  end

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(row) < SCREEN_ROWS) && (int'(col) < SCREEN_COLS))
    else $error("cursor outside the screen");

  // Memory writes stay inside the cell store
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (int'(mreq.waddr) < CELL_COUNT))
    else $error("cell write outside the store");

  // A transfer is followed by busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");

  // A result strobe lasts one cycle and returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  // Reads outside the idle state only during scroll or scan
  a_read_scan: assert property (@(posedge clk) disable iff (rst)
    (mreq.re && state != S_IDLE) |-> (state == S_SCROLL || state == S_SCAN_RD))
    else $error("unexpected cell read");

endmodule

// File: rtl/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: text console cursor engine
// Keeps a screen of 16-bit cells and a cursor; puts characters, clears the
// screen and reads cells back, one command at a time.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start, busy          | mode, char_code, read_col, read_row
//  result    | done (strobe)        | cursor_pos, read_char
//  config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
//  Plain character, newline, backspace in a row or refused, mode 3, off-screen
//  read: the result state follows the transfer directly, unless a put scrolls.
//  On-screen read: via S_RD_WAIT (registered memory read).
//  Backspace at column 0: one S_SCAN_RD and S_SCAN_CMP per scanned cell,
//  one memory read and compare each step. Scroll: one cell copied per cycle,
//  then the last row filled with spaces. Clear: fills all CELL_COUNT cells.
//  After reset a clearing pass writes all CELL_COUNT cells with
//  busy high; config writes are taken meanwhile. The receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [COL_W-1:0]      read_col,
  input  logic [ROW_W-1:0]      read_row,
  // result
  output logic                  done,
  output logic [POS_W-1:0]      cursor_pos,
  output logic [CHAR_W-1:0]     read_char,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] text_color;
  logic [POS_W-1:0]   erase_limit;
  mem_req_t           mreq;
  logic [CELL_W-1:0]  rdata;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= RESET_COLOR;
      erase_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_COLOR:  text_color  <= cfg_data[COLOR_W-1:0];
        CFG_ERASE_LIMIT: erase_limit <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  tcce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .char_code   (char_code),
    .read_col    (read_col),
    .read_row    (read_row),
    .text_color  (text_color),
    .erase_limit (erase_limit),
    .rdata       (rdata),
    .mreq        (mreq),
    .busy        (busy),
    .done        (done),
    .cursor_pos  (cursor_pos),
    .read_char   (read_char)
  );

  // Cell store
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

endmodule
